// File: rtl/interval_timer_two_channel_core_macros.svh
// ---------------------------------------------------------------------------
// interval timer assertion macros
// shared property wrappers for the interval timer core
// ---------------------------------------------------------------------------
`ifndef INTERVAL_TIMER_TWO_CHANNEL_CORE_MACROS_SVH
`define INTERVAL_TIMER_TWO_CHANNEL_CORE_MACROS_SVH

// implication checked on every edge outside reset
`define ITMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// implication checked on every edge, reset included
`define ITMR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/itmr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// itmr_pkg
// port addresses, opcodes, control bits and helpers of the interval timer
// ---------------------------------------------------------------------------
package itmr_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  localparam logic [7:0] PORT_CH0  = 8'h40;
  localparam logic [7:0] PORT_CH2  = 8'h42;
  localparam logic [7:0] PORT_CMD  = 8'h43;
  localparam logic [7:0] PORT_CTRL = 8'h61;

  localparam logic [7:0] CTRL_GATE    = 8'h01;
  localparam logic [7:0] CTRL_SPEAKER = 8'h02;
  localparam logic [7:0] CTRL_OUT2    = 8'h20;

  // counter select codes in command bits 7:6
  localparam logic [1:0] SEL_CH0 = 2'd0;
  localparam logic [1:0] SEL_CH2 = 2'd2;
  localparam logic [1:0] ACCESS_LATCH = 2'd0;

  // channel indexes of the state arrays
  localparam logic CH0 = 1'b0;
  localparam logic CH2 = 1'b1;

  localparam logic [1:0] MODE_SQUARE_LOW = 2'd3;

  typedef logic [15:0] count_t;

  function automatic logic is_square(input logic [2:0] mode);
    is_square = (mode[1:0] == MODE_SQUARE_LOW);
  endfunction

  // count for the next half period of the square wave
  function automatic count_t load_half(input count_t n, input logic level);
    count_t r;
    if (n[0]) begin
      if (level) begin
        r = n + 16'd1;
      end else if (n == 16'd1) begin
        r = 16'd2;
      end else begin
        r = n - 16'd1;
      end
    end else begin
      r = n;
    end
    load_half = r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/interval_timer_two_channel_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// interval_timer_two_channel_core
// counters 0 and 2 of an 8254-style timer with the 0x61 gate/speaker port
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  opcode, port, write_data
//  out      out_valid / out_stall read_data, tick_irq, speaker_level
//
//  one request per cycle sustained while the result is not stalled; each goes from
//  acceptance to result through the input register, then a single-pass update
//  into the result register; reset clears all timer state, no clearing pass
//  a stalled result holds while one more request waits in the input register
// ---------------------------------------------------------------------------
module interval_timer_two_channel_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire itmr_pkg::opcode_t   opcode,
  input  wire logic [7:0]          port,
  input  wire logic [7:0]          write_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      logic [7:0]          read_data,
  output      logic                tick_irq,
  output      logic                speaker_level
);
  import itmr_pkg::*;

  // input register
  logic      s1_valid;
  opcode_t   s1_op;
  logic [7:0] s1_port;
  logic [7:0] s1_data;

  logic s2_load;

  // timer state
  count_t     counter_value [2];
  count_t     reload_value [2];
  logic [2:0] mode_select [2];
  logic       byte_toggle [2];
  logic [7:0] low_byte_hold [2];
  logic       out_level [2];
  logic       counting_active [2];
  logic       gate_two;
  logic       speaker_enable;

  count_t     counter_value_next [2];
  count_t     reload_value_next [2];
  logic [2:0] mode_select_next [2];
  logic       byte_toggle_next [2];
  logic [7:0] low_byte_hold_next [2];
  logic       out_level_next [2];
  logic       counting_active_next [2];
  logic       gate_two_next;
  logic       speaker_enable_next;

  logic [7:0] read_data_next;
  logic       tick_irq_next;

  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op   <= opcode;
      s1_port <= port;
      s1_data <= write_data;
    end
  end

  always_comb begin
    count_t     cv;
    count_t     rv;
    logic       ch;
    logic       gate;
    logic       lvl;
    counter_value_next   = counter_value;
    reload_value_next    = reload_value;
    mode_select_next     = mode_select;
    byte_toggle_next     = byte_toggle;
    low_byte_hold_next   = low_byte_hold;
    out_level_next       = out_level;
    counting_active_next = counting_active;
    gate_two_next        = gate_two;
    speaker_enable_next  = speaker_enable;
    read_data_next       = 8'h00;
    tick_irq_next        = 1'b0;
    ch = CH0;
    cv = '0;
    rv = '0;
    gate = 1'b0;
    lvl = 1'b0;

    case (s1_op)
      OP_TICK: begin
        for (int c = 0; c < 2; c++) begin
          gate = (c == 0) ? 1'b1 : gate_two;
          if (counting_active[c] && gate) begin
            if (is_square(mode_select[c])) begin
              cv = counter_value[c] - 16'd2;
              if (cv == 16'd0) begin
                lvl = ~out_level[c];
                out_level_next[c] = lvl;
                cv = load_half(reload_value[c], lvl);
                if (c == 0) tick_irq_next = lvl;
              end
              counter_value_next[c] = cv;
            end else begin
              cv = counter_value[c] - 16'd1;
              counter_value_next[c] = cv;
              if (cv == 16'd0 && !out_level[c]) begin
                out_level_next[c] = 1'b1;
                if (c == 0) tick_irq_next = 1'b1;
              end
            end
          end
        end
      end
      OP_WRITE: begin
        if (s1_port == PORT_CMD) begin
          if ((s1_data[7:6] == SEL_CH0 || s1_data[7:6] == SEL_CH2) &&
              s1_data[5:4] != ACCESS_LATCH) begin
            ch = (s1_data[7:6] == SEL_CH2) ? CH2 : CH0;
            mode_select_next[ch]     = s1_data[3:1];
            byte_toggle_next[ch]     = 1'b0;
            counting_active_next[ch] = 1'b0;
            out_level_next[ch]       = is_square(s1_data[3:1]);
          end
        end else if (s1_port == PORT_CH0 || s1_port == PORT_CH2) begin
          ch = (s1_port == PORT_CH2) ? CH2 : CH0;
          if (!byte_toggle[ch]) begin
            low_byte_hold_next[ch] = s1_data;
            byte_toggle_next[ch]   = 1'b1;
          end else begin
            rv = {s1_data, low_byte_hold[ch]};
            byte_toggle_next[ch]     = 1'b0;
            reload_value_next[ch]    = rv;
            counting_active_next[ch] = 1'b1;
            if (is_square(mode_select[ch])) begin
              out_level_next[ch]     = 1'b1;
              counter_value_next[ch] = load_half(rv, 1'b1);
            end else begin
              out_level_next[ch]     = 1'b0;
              counter_value_next[ch] = rv;
            end
          end
        end else if (s1_port == PORT_CTRL) begin
          gate_two_next       = s1_data[0];
          speaker_enable_next = s1_data[1];
          if (is_square(mode_select[CH2])) begin
            if (!s1_data[0]) begin
              out_level_next[CH2] = 1'b1;
            end else if (!gate_two && counting_active[CH2]) begin
              // rising gate restarts the half period
              out_level_next[CH2]     = 1'b1;
              counter_value_next[CH2] = load_half(reload_value[CH2], 1'b1);
            end
          end
        end
      end
      OP_READ: begin
        if (s1_port == PORT_CH0) begin
          read_data_next = counter_value[CH0][7:0];
        end else if (s1_port == PORT_CH2) begin
          read_data_next = counter_value[CH2][7:0];
        end else if (s1_port == PORT_CTRL) begin
          read_data_next = (gate_two ? CTRL_GATE : 8'h00) |
                           (speaker_enable ? CTRL_SPEAKER : 8'h00) |
                           (out_level[CH2] ? CTRL_OUT2 : 8'h00);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        counter_value[c]   <= '0;
        reload_value[c]    <= '0;
        mode_select[c]     <= '0;
        byte_toggle[c]     <= 1'b0;
        low_byte_hold[c]   <= '0;
        out_level[c]       <= 1'b1;
        counting_active[c] <= 1'b0;
      end
      gate_two       <= 1'b0;
      speaker_enable <= 1'b0;
    end else if (s2_load) begin
      counter_value   <= counter_value_next;
      reload_value    <= reload_value_next;
      mode_select     <= mode_select_next;
      byte_toggle     <= byte_toggle_next;
      low_byte_hold   <= low_byte_hold_next;
      out_level       <= out_level_next;
      counting_active <= counting_active_next;
      gate_two        <= gate_two_next;
      speaker_enable  <= speaker_enable_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      read_data     <= read_data_next;
      tick_irq      <= tick_irq_next;
      speaker_level <= out_level_next[CH2] & speaker_enable_next;
    end
  end

`include "interval_timer_two_channel_core_macros.svh"

  `ITMR_ASSERT_ALWAYS(a_stall_needs_held_request, in_stall |-> s1_valid, "stall without request held")
  `ITMR_ASSERT(a_cmd_stops_ch0, (s2_load && s1_op == OP_WRITE && s1_port == PORT_CMD && s1_data[7:6] == SEL_CH0 && s1_data[5:4] != ACCESS_LATCH) |=> !counting_active[CH0], "command did not stop counter 0")
  `ITMR_ASSERT(a_high_byte_starts_ch0, (s2_load && s1_op == OP_WRITE && s1_port == PORT_CH0 && byte_toggle[CH0]) |=> (counting_active[CH0] && !byte_toggle[CH0]), "high byte did not start counter 0")
  `ITMR_ASSERT(a_gate_low_square_high, (!gate_two && is_square(mode_select[CH2])) |-> out_level[CH2], "counter 2 square output low with gate low")

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
// ---------------------------------------------------------------------------
// interval timer core testbench
// drives tick, port write and port read requests into the two-channel timer,
// predicts every result from a behavioural copy of the counters and compares
// each returned request result field by field, with random idling on both
// sides and two long output hold-offs
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import itmr_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 9;
  localparam int HOLD_OFF_CYCLES = 60;
  localparam int CYCLE_LIMIT     = 300000;
  localparam int DRAIN_CYCLES    = 6;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tick_irq;
    logic       speaker_level;
  } timer_result_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  opcode_t    opcode;
  logic [7:0] port;
  logic [7:0] write_data;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] read_data;
  logic       tick_irq;
  logic       speaker_level;

  interval_timer_two_channel_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .port          (port),
    .write_data    (write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .read_data     (read_data),
    .tick_irq      (tick_irq),
    .speaker_level (speaker_level)
  );

  // timer state as the block should hold it
  count_t     count_now [2];
  count_t     count_load[2];
  logic [2:0] mode_of   [2];
  logic       high_next [2];
  logic [7:0] low_held  [2];
  logic       out_now   [2];
  logic       running   [2];
  logic       gate2;
  logic       spk_en;

  timer_result_t expected_results[$];
  int            error_count;
  int            requests_sent;
  int            hold_off_requests;
  int            cycle_count;
  logic          tx_idle_on;
  logic          rx_idle_on;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---- prediction ---------------------------------------------------------

  task automatic clear_timer_state();
    for (int ch = 0; ch < 2; ch++) begin
      count_now[ch]  = '0;
      count_load[ch] = '0;
      mode_of[ch]    = '0;
      high_next[ch]  = 1'b0;
      low_held[ch]   = '0;
      out_now[ch]    = 1'b1;
      running[ch]    = 1'b0;
    end
    gate2  = 1'b0;
    spk_en = 1'b0;
  endtask

  function automatic logic square_mode(logic ch);
    return mode_of[ch][1:0] == MODE_SQUARE_LOW;
  endfunction

  // odd counts split into a longer high and a shorter low half
  function automatic count_t next_half_count(logic ch);
    count_t n;
    n = count_load[ch];
    if (!n[0]) return n;
    if (out_now[ch]) return n + 16'd1;
    return (n == 16'd1) ? 16'd2 : n - 16'd1;
  endfunction

  function automatic logic clock_channel(logic ch);
    if (!running[ch] || (ch == CH2 && !gate2)) return 1'b0;
    if (square_mode(ch)) begin
      count_now[ch] = count_now[ch] - 16'd2;
      if (count_now[ch] == 16'd0) begin
        out_now[ch]   = ~out_now[ch];
        count_now[ch] = next_half_count(ch);
        return out_now[ch];
      end
      return 1'b0;
    end
    count_now[ch] = count_now[ch] - 16'd1;
    if (count_now[ch] == 16'd0 && !out_now[ch]) begin
      out_now[ch] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void apply_command(logic [7:0] d);
    logic ch;
    if (d[7:6] == SEL_CH0) begin
      ch = CH0;
    end else if (d[7:6] == SEL_CH2) begin
      ch = CH2;
    end else begin
      return;
    end
    if (d[5:4] == ACCESS_LATCH) return;
    mode_of[ch]   = d[3:1];
    high_next[ch] = 1'b0;
    running[ch]   = 1'b0;
    out_now[ch]   = square_mode(ch);
  endfunction

  function automatic void apply_count_byte(logic ch, logic [7:0] d);
    if (!high_next[ch]) begin
      low_held[ch]  = d;
      high_next[ch] = 1'b1;
      return;
    end
    high_next[ch]  = 1'b0;
    count_load[ch] = {d, low_held[ch]};
    running[ch]    = 1'b1;
    if (square_mode(ch)) begin
      out_now[ch]   = 1'b1;
      count_now[ch] = next_half_count(ch);
    end else begin
      out_now[ch]   = 1'b0;
      count_now[ch] = count_load[ch];
    end
  endfunction

  function automatic void apply_control(logic [7:0] d);
    logic was_gated;
    was_gated = gate2;
    gate2  = |(d & CTRL_GATE);
    spk_en = |(d & CTRL_SPEAKER);
    if (square_mode(CH2)) begin
      if (!gate2) begin
        out_now[CH2] = 1'b1;
      end else if (!was_gated && running[CH2]) begin
        // rising gate restarts the half period
        out_now[CH2]   = 1'b1;
        count_now[CH2] = next_half_count(CH2);
      end
    end
  endfunction

  function automatic timer_result_t step_timer(opcode_t op, logic [7:0] p, logic [7:0] d);
    timer_result_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        r.tick_irq = clock_channel(CH0);
        void'(clock_channel(CH2));
      end
      OP_WRITE: begin
        if (p == PORT_CMD) apply_command(d);
        else if (p == PORT_CH0) apply_count_byte(CH0, d);
        else if (p == PORT_CH2) apply_count_byte(CH2, d);
        else if (p == PORT_CTRL) apply_control(d);
      end
      OP_READ: begin
        if (p == PORT_CH0) r.read_data = count_now[CH0][7:0];
        else if (p == PORT_CH2) r.read_data = count_now[CH2][7:0];
        else if (p == PORT_CTRL)
          r.read_data = (gate2 ? CTRL_GATE : 8'h00) | (spk_en ? CTRL_SPEAKER : 8'h00) |
                        (out_now[CH2] ? CTRL_OUT2 : 8'h00);
      end
      default: ;
    endcase
    r.speaker_level = out_now[CH2] & spk_en;
    return r;
  endfunction

  // ---- request side -------------------------------------------------------

  task automatic send_request(input opcode_t op, input logic [7:0] p, input logic [7:0] d);
    int gap;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    port       <= p;
    write_data <= d;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(step_timer(op, p, d));
    requests_sent++;
  endtask

  // ---- result side --------------------------------------------------------

  initial begin : result_sink
    int served;
    int burst;
    served    = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_requests != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    timer_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, read_data %02h tick_irq %0b spk %0b",
                 $time, read_data, tick_irq, speaker_level);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (read_data !== exp_r.read_data) begin
          $display("%0t: read_data expected %02h actual %02h", $time, exp_r.read_data,
                   read_data);
          error_count++;
        end
        if (tick_irq !== exp_r.tick_irq) begin
          $display("%0t: tick_irq expected %0b actual %0b", $time, exp_r.tick_irq, tick_irq);
          error_count++;
        end
        if (speaker_level !== exp_r.speaker_level) begin
          $display("%0t: speaker_level expected %0b actual %0b", $time, exp_r.speaker_level,
                   speaker_level);
          error_count++;
        end
      end
    end
  end

  // ---- stimulus -----------------------------------------------------------

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_request(OP_TICK, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_directed_cases();
    send_request(OP_READ, PORT_CTRL, 8'h00);
    send_request(OP_READ, PORT_CMD, 8'h00);
    send_request(OP_NONE, 8'hFF, 8'hFF);
    send_request(OP_WRITE, PORT_CMD, 8'h76);   // counter 1 select, ignored
    send_request(OP_WRITE, PORT_CMD, 8'h06);   // latch access, ignored
    send_request(OP_WRITE, PORT_CMD, 8'hB7);   // channel 2 square wave, bcd bit set
    send_request(OP_WRITE, PORT_CH2, 8'h03);   // odd count
    send_request(OP_WRITE, PORT_CH2, 8'h00);
    send_request(OP_WRITE, PORT_CTRL, 8'h03);  // rising gate, speaker on
    send_ticks(4);
    send_request(OP_READ, PORT_CTRL, 8'h00);
    send_request(OP_WRITE, PORT_CTRL, 8'h02);  // gate low forces output high
    send_ticks(1);
    send_request(OP_WRITE, PORT_CMD, 8'h1E);   // low-only access, mode 7
    send_request(OP_WRITE, PORT_CH0, 8'h01);   // count of one
    send_request(OP_WRITE, PORT_CH0, 8'h00);
    send_ticks(2);
    send_request(OP_WRITE, PORT_CMD, 8'h32);   // mode 1 runs as one-shot
    send_request(OP_WRITE, PORT_CH0, 8'h00);   // count of zero
    send_request(OP_WRITE, PORT_CH0, 8'h00);
    send_ticks(1);
    send_request(OP_READ, PORT_CH0, 8'h00);
    send_request(OP_WRITE, 8'hFF, 8'hFF);
    send_request(OP_READ, 8'hFF, 8'h00);
  endtask

  function automatic logic [7:0] pick_known_port();
    case ($urandom_range(0, 3))
      0:       return PORT_CH0;
      1:       return PORT_CH2;
      2:       return PORT_CMD;
      default: return PORT_CTRL;
    endcase
  endfunction

  // mostly small counts so that terminal count and toggles come often
  task automatic program_channel(input logic two);
    logic [7:0] cmd;
    logic [7:0] lo;
    logic [7:0] hi;
    cmd[7:6] = two ? SEL_CH2 : SEL_CH0;
    if ($urandom_range(0, 15) == 0) cmd[7:6] = 2'($urandom);
    cmd[5:4] = ($urandom_range(0, 15) == 0) ? ACCESS_LATCH : 2'($urandom_range(1, 3));
    cmd[3:0] = 4'($urandom);
    lo = 8'($urandom_range(0, 24));
    hi = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
    if ($urandom_range(0, 9) == 0) lo = 8'($urandom);
    send_request(OP_WRITE, PORT_CMD, cmd);
    send_request(OP_WRITE, two ? PORT_CH2 : PORT_CH0, lo);
    send_request(OP_WRITE, two ? PORT_CH2 : PORT_CH0, hi);
  endtask

  task automatic run_timer_traffic(input int n);
    int stop_at;
    stop_at = requests_sent + n;
    while (requests_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: program_channel(1'($urandom_range(0, 1)));
        3:       send_request(OP_WRITE, PORT_CTRL, ($urandom_range(0, 3) == 0) ?
                                8'($urandom) : 8'($urandom_range(0, 3)));
        4, 5, 6: send_ticks($urandom_range(1, 20));
        7:       send_request(OP_READ, pick_known_port(), 8'($urandom));
        8:       send_request(opcode_t'($urandom_range(0, 3)),
                              ($urandom_range(0, 1) == 0) ? pick_known_port() : 8'($urandom),
                              8'($urandom));
        default: begin
          // broken programming: a lone command or a lone count byte
          if ($urandom_range(0, 1) == 0) send_request(OP_WRITE, PORT_CMD, 8'($urandom));
          else send_request(OP_WRITE, ($urandom_range(0, 1) == 0) ? PORT_CH0 : PORT_CH2,
                            8'($urandom));
        end
      endcase
    end
  endtask

  task automatic test_random_traffic();
    for (int chunk = 0; chunk < 8; chunk++) begin
      tx_idle_on = (chunk % 4) != 3 && chunk != 1;
      rx_idle_on = (chunk % 4) != 3 && chunk != 2;
      run_timer_traffic(125);
    end
  endtask

  task automatic test_output_hold_off();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int k = 0; k < 2; k++) begin
      hold_off_requests++;
      program_channel(1'b0);
      send_ticks(30);
      send_request(OP_READ, PORT_CH0, 8'h00);
      send_request(OP_READ, PORT_CTRL, 8'h00);
    end
  endtask

  task automatic test_quiet_finish();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_timer_traffic(250);
  endtask

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    opcode            = OP_TICK;
    port              = '0;
    write_data        = '0;
    error_count       = 0;
    requests_sent     = 0;
    hold_off_requests = 0;
    cycle_count       = 0;
    tx_idle_on        = 1'b1;
    rx_idle_on        = 1'b1;
    clear_timer_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_random_traffic();
    test_output_hold_off();
    test_quiet_finish();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
